FILE: sv/lir_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lir_pkg: shared types and constants of the linear interpolation resampler
// Sample width, word formats, register indexes and queue item encoding.
// ----------------------------------------------------------------------------
package lir_pkg;

	// fixed sample format, q1.23
	localparam int SAMPLE_W    = 24;
	// width of the emitted-output counter
	localparam int EMIT_W      = 35;
	// most results one input word can cause
	localparam int MAX_RESULTS = 18;
	localparam int RES_W       = $clog2(MAX_RESULTS + 1);
	// digit width of the serial total multiplier
	localparam int DIGIT_W     = 8;
	localparam int CFG_IDX_W   = 2;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BYPASS = 2'd0,
		REG_STEP   = 2'd1,
		REG_RATIO  = 2'd2
	} cfg_reg_t;

	// how the back end treats a queued word
	typedef enum logic [1:0] {
		ITEM_DROP   = 2'd0,
		ITEM_PASS   = 2'd1,
		ITEM_INTERP = 2'd2
	} item_kind_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_value;
		logic                       is_last;
	} in_word_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] out_value;
		logic                       end_of_run;
		logic                       end_of_stream;
	} out_word_t;

	typedef struct packed {
		item_kind_t                 kind;
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last;
	} q_item_t;

endpackage

FILE: sv/lir_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lir_front: input classifier and word queue
// Tags each accepted word as dropped, passed or interpolated and holds it
// in a two-entry queue until the back end takes it.
// ----------------------------------------------------------------------------
module lir_front import lir_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     bypass,
	input  logic     ratio_zero,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_word_t in_data,
	output logic     head_valid,
	output q_item_t  head,
	input  logic     pop
);

	localparam int QDEPTH = 2;
	localparam int PTR_W  = $clog2(QDEPTH);
	localparam int CNT_W  = $clog2(QDEPTH + 1);

	q_item_t          slot_q [QDEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	q_item_t          item;
	logic             push;

	// classify the incoming word
	always_comb begin
		item.sample = in_data.sample_value;
		item.last   = in_data.is_last;
		if (ratio_zero) begin
			item.kind = ITEM_DROP;
		end else if (bypass) begin
			item.kind = ITEM_PASS;
		end else begin
			item.kind = ITEM_INTERP;
		end
	end

	assign in_ready   = (cnt_q != CNT_W'(QDEPTH));
	assign push       = in_valid && in_ready;
	assign head_valid = (cnt_q != '0);
	assign head       = slot_q[rd_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= item;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// a pop never runs ahead of the queue
	a_pop_has_word: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(QDEPTH))
		else $error("queue fill count out of range");

endmodule

FILE: sv/lir_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lir_back: interpolation sequencer and output register
// Holds stream state, emits interpolated words one per cycle unless the output
// stalls, works out the stream total on the last word and pads with copies.
// ----------------------------------------------------------------------------
module lir_back import lir_pkg::*; #(
	parameter int FRAC_BITS  = 24,
	parameter int COUNT_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [FRAC_BITS+4:0] input_step,
	input  logic [FRAC_BITS+3:0] output_ratio,
	input  logic                 head_valid,
	input  q_item_t              head,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_word_t            out_data
);

	localparam int NP_W    = FRAC_BITS + 5;
	localparam int RATIO_W = FRAC_BITS + 4;
	localparam int CNT_W   = COUNT_BITS + 1;
	localparam int NDIG    = (CNT_W + DIGIT_W - 1) / DIGIT_W;
	localparam int PW      = NDIG * DIGIT_W;
	localparam int ACC_W   = PW + RATIO_W;
	localparam int TOT_W   = ACC_W - FRAC_BITS;
	localparam int CMP_W   = (TOT_W > EMIT_W) ? TOT_W : EMIT_W;
	localparam int DG_W    = $clog2(NDIG);
	localparam int DIF_W   = SAMPLE_W + 1;
	localparam int PROD_W  = SAMPLE_W + FRAC_BITS + 3;
	localparam int DPR_W   = RATIO_W + DIGIT_W;

	localparam logic [NP_W-1:0]           ONE_POS   = NP_W'(1) << FRAC_BITS;
	localparam logic [NP_W-1:0]           STEP_MIN  = ONE_POS >> 3;
	localparam logic [NP_W-1:0]           STEP_MAX  = ONE_POS << 4;
	localparam logic [RATIO_W-1:0]        RATIO_MAX = RATIO_W'(1) << (FRAC_BITS + 3);
	localparam logic [ACC_W-1:0]          HALF_ACC  = ACC_W'(1) << (FRAC_BITS - 1);
	localparam logic signed [PROD_W-1:0]  HALF_P    = PROD_W'(1) << (FRAC_BITS - 1);
	localparam logic [COUNT_BITS-1:0]     SEEN_MAX  = '1;
	localparam logic [EMIT_W-1:0]         EMIT_MAX  = '1;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_MUL  = 6'b000010,
		S_RND  = 6'b000100,
		S_REM  = 6'b001000,
		S_EMIT = 6'b010000,
		S_PAD  = 6'b100000
	} state_t;

	state_t                     state_q;
	// stream state
	logic signed [SAMPLE_W-1:0] prev_q;
	logic [NP_W-1:0]            next_pos_q;
	logic [COUNT_BITS-1:0]      seen_q;
	logic [EMIT_W-1:0]          emitted_q;
	// per-word working registers
	logic signed [SAMPLE_W-1:0] cur_q;
	logic                       last_q;
	logic                       first_q;
	logic signed [SAMPLE_W-1:0] base_q;
	logic signed [DIF_W-1:0]    diff_q;
	logic [RES_W-1:0]           rem_q;
	logic [RES_W-1:0]           n_q;
	logic [ACC_W-1:0]           acc_q;
	logic [PW-1:0]              cnt_sh_q;
	logic [DG_W-1:0]            dig_q;
	logic [TOT_W-1:0]           total_q;
	// output register
	logic                       out_valid_q;
	out_word_t                  out_word_q;

	logic [NP_W-1:0]            step_c;
	logic [RATIO_W-1:0]         ratio_c;
	logic [NP_W-1:0]            limit;
	logic [NP_W-1:0]            np_adv;
	logic [RES_W-1:0]           n_inc;
	logic                       can_push;
	logic                       cond;
	logic                       emit_final;
	logic                       pad_final;
	logic                       push;
	out_word_t                  push_word;
	logic                       seen_zero;
	logic signed [SAMPLE_W-1:0] prev_eff;
	logic signed [PROD_W-1:0]   diff_x;
	logic signed [PROD_W-1:0]   t_x;
	logic signed [PROD_W-1:0]   rnd;
	logic signed [DIF_W-1:0]    delta;
	logic signed [DIF_W-1:0]    interp_sum;
	logic [DPR_W-1:0]           dprod;
	logic [CMP_W-1:0]           tot_x;
	logic [CMP_W-1:0]           em_x;
	logic [CMP_W-1:0]           gap;

	// saturate step and ratio into their working ranges
	always_comb begin
		if (input_step < STEP_MIN) begin
			step_c = STEP_MIN;
		end else if (input_step > STEP_MAX) begin
			step_c = STEP_MAX;
		end else begin
			step_c = input_step;
		end
		ratio_c = (output_ratio > RATIO_MAX) ? RATIO_MAX : output_ratio;
	end

	// interpolation datapath: base + round(diff * t)
	assign diff_x     = PROD_W'(diff_q);
	assign t_x        = PROD_W'({1'b0, next_pos_q[FRAC_BITS:0]});
	assign rnd        = diff_x * t_x + HALF_P;
	assign delta      = rnd[FRAC_BITS +: DIF_W];
	assign interp_sum = {base_q[SAMPLE_W-1], base_q} + delta;

	// loop control
	assign limit      = first_q ? '0 : ONE_POS;
	assign np_adv     = next_pos_q + step_c;
	assign n_inc      = n_q + RES_W'(1);
	assign can_push   = !out_valid_q || out_ready;
	assign cond       = (next_pos_q <= limit) && (n_q < rem_q);
	assign emit_final = (n_inc == rem_q) || (!last_q && (np_adv > limit));
	assign pad_final  = (n_inc == rem_q);

	// first word of a stream interpolates against itself
	assign seen_zero  = (seen_q == '0);
	assign prev_eff   = seen_zero ? head.sample : prev_q;

	// one digit of the stream-length product per cycle
	assign dprod = {{DIGIT_W{1'b0}}, ratio_c} *
		{{RATIO_W{1'b0}}, cnt_sh_q[PW-1 -: DIGIT_W]};

	// remaining results once the total is known
	assign tot_x = CMP_W'(total_q);
	assign em_x  = CMP_W'(emitted_q);
	assign gap   = tot_x - em_x;

	// queue pop and result word selection
	always_comb begin
		pop                     = 1'b0;
		push                    = 1'b0;
		push_word.out_value     = interp_sum[SAMPLE_W-1:0];
		push_word.end_of_run    = emit_final;
		push_word.end_of_stream = emit_final && last_q;
		unique case (state_q)
			S_IDLE: begin
				pop = head_valid && ((head.kind != ITEM_PASS) || can_push);
				if (pop && (head.kind == ITEM_PASS)) begin
					push                    = 1'b1;
					push_word.out_value     = head.sample;
					push_word.end_of_run    = 1'b1;
					push_word.end_of_stream = head.last;
				end
			end
			S_EMIT: begin
				push = cond && can_push;
			end
			S_PAD: begin
				push                    = (n_q < rem_q) && can_push;
				push_word.out_value     = cur_q;
				push_word.end_of_run    = pad_final;
				push_word.end_of_stream = pad_final;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	// sequencer, stream state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			prev_q      <= '0;
			next_pos_q  <= '0;
			seen_q      <= '0;
			emitted_q   <= '0;
			cur_q       <= '0;
			last_q      <= 1'b0;
			first_q     <= 1'b0;
			base_q      <= '0;
			diff_q      <= '0;
			rem_q       <= '0;
			n_q         <= '0;
			acc_q       <= '0;
			cnt_sh_q    <= '0;
			dig_q       <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
			out_word_q  <= '0;
		end else begin
			if (can_push) begin
				out_valid_q <= push;
			end
			if (push) begin
				out_word_q <= push_word;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						cur_q  <= head.sample;
						last_q <= head.last;
						n_q    <= '0;
						case (head.kind)
							ITEM_INTERP: begin
								first_q <= seen_zero;
								base_q  <= prev_eff;
								diff_q  <= {head.sample[SAMPLE_W-1], head.sample} -
									{prev_eff[SAMPLE_W-1], prev_eff};
								prev_q  <= prev_eff;
								if (head.last) begin
									cnt_sh_q <= PW'(seen_q) + PW'(1);
									acc_q    <= '0;
									dig_q    <= DG_W'(NDIG - 1);
									state_q  <= S_MUL;
								end else begin
									rem_q   <= RES_W'(MAX_RESULTS);
									state_q <= S_EMIT;
								end
							end
							ITEM_PASS: begin
								if (head.last) begin
									prev_q     <= '0;
									next_pos_q <= '0;
									seen_q     <= '0;
									emitted_q  <= '0;
								end else if (seen_q != SEEN_MAX) begin
									seen_q <= seen_q + COUNT_BITS'(1);
								end
							end
							default: begin
								// dropped word still ends the stream
								if (head.last) begin
									prev_q     <= '0;
									next_pos_q <= '0;
									seen_q     <= '0;
									emitted_q  <= '0;
								end
							end
						endcase
					end
				end
				S_MUL: begin
					acc_q    <= (acc_q << DIGIT_W) + ACC_W'(dprod);
					cnt_sh_q <= cnt_sh_q << DIGIT_W;
					if (dig_q == '0) begin
						state_q <= S_RND;
					end else begin
						dig_q <= dig_q - DG_W'(1);
					end
				end
				S_RND: begin
					total_q <= TOT_W'((acc_q + HALF_ACC) >> FRAC_BITS);
					state_q <= S_REM;
				end
				S_REM: begin
					if (tot_x > em_x) begin
						rem_q <= (gap >= CMP_W'(MAX_RESULTS)) ?
							RES_W'(MAX_RESULTS) : gap[RES_W-1:0];
					end else begin
						rem_q <= '0;
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (cond) begin
						if (can_push) begin
							n_q        <= n_inc;
							next_pos_q <= np_adv;
							if (emitted_q != EMIT_MAX) begin
								emitted_q <= emitted_q + EMIT_W'(1);
							end
						end
					end else if (last_q) begin
						state_q <= S_PAD;
					end else begin
						if (!first_q) begin
							next_pos_q <= (next_pos_q > ONE_POS) ?
								next_pos_q - ONE_POS : '0;
						end
						prev_q <= cur_q;
						if (seen_q != SEEN_MAX) begin
							seen_q <= seen_q + COUNT_BITS'(1);
						end
						state_q <= S_IDLE;
					end
				end
				S_PAD: begin
					if (n_q < rem_q) begin
						if (can_push) begin
							n_q <= n_inc;
						end
					end else begin
						prev_q     <= '0;
						next_pos_q <= '0;
						seen_q     <= '0;
						emitted_q  <= '0;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_word_q;

	// result count never passes its bound
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT || state_q == S_PAD) |-> (n_q <= rem_q) &&
			(rem_q <= RES_W'(MAX_RESULTS)))
		else $error("result count past its bound");

	// interpolation weight stays within one sample interval
	a_weight_range: assert property (@(posedge clk) disable iff (!arst_n)
		(push && state_q == S_EMIT) |-> next_pos_q <= ONE_POS)
		else $error("interpolation position outside interval");

	// the stream's final word also closes its run
	a_eos_closes_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_word_q.end_of_stream) |-> out_word_q.end_of_run)
		else $error("end of stream without end of run");

	// digit multiply runs straight into rounding
	a_mul_flow: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL) |=> (state_q == S_MUL || state_q == S_RND))
		else $error("multiply sequence broken");

endmodule

FILE: sv/linear_interpolation_resampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_interpolation_resampler: linear interpolation sample rate converter
// Resamples a stream of q1.23 samples by a fixed-point step, pads the
// stream to its rounded total on the last sample, with a bypass mode.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  in       input      in_valid / in_ready    in_data  (sample_value, is_last)
//  out      output     out_valid / out_ready  out_data (out_value, end_of_run,
//                                                       end_of_stream)
//  cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Passed and dropped words are handled in the idle state as they are popped.
// An interpolated word is loaded, emits its results and closes; a last word
// first multiplies the sample count by the ratio one 8-bit digit at a time
// (5 digits at COUNT_BITS = 32), rounds and clamps the total in S_RND and
// S_REM, pads with copies and clears the stream.
// A two-word queue lets the input run ahead of the sequencer; the output
// register holds the sequencer while it holds a word and out_ready is low.
// Reset clears the stream state and loads step and ratio with one.
// ----------------------------------------------------------------------------
module linear_interpolation_resampler import lir_pkg::*; #(
	parameter int FRAC_BITS  = 24,
	parameter int COUNT_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_word_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_word_t            out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [FRAC_BITS+4:0] cfg_data
);

	localparam int STEP_W  = FRAC_BITS + 5;
	localparam int RATIO_W = FRAC_BITS + 4;
	localparam logic [STEP_W-1:0]  STEP_RESET  = STEP_W'(1) << FRAC_BITS;
	localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(1) << FRAC_BITS;

	logic               bypass_q;
	logic [STEP_W-1:0]  step_q;
	logic [RATIO_W-1:0] ratio_q;
	logic               head_valid;
	q_item_t            head;
	logic               pop;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bypass_q <= 1'b0;
			step_q   <= STEP_RESET;
			ratio_q  <= RATIO_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_BYPASS: bypass_q <= cfg_data[0];
				REG_STEP:   step_q   <= cfg_data;
				REG_RATIO:  ratio_q  <= cfg_data[RATIO_W-1:0];
				default: begin
					bypass_q <= bypass_q;
				end
			endcase
		end
	end

	lir_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.bypass     (bypass_q),
		.ratio_zero (ratio_q == '0),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	lir_back #(
		.FRAC_BITS  (FRAC_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.input_step   (step_q),
		.output_ratio (ratio_q),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_data     (out_data)
	);

endmodule

FILE: sim/lir_output_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lir_output_checker: output prediction and comparison for the resampler
// Follows register writes and accepted input words, predicts every output
// word of the resampler, and compares each accepted output word with the
// oldest prediction, field by field.
// ----------------------------------------------------------------------------
module lir_output_checker import lir_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  in_word_t             in_data,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  out_word_t            out_data,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [28:0]          cfg_data,
	output int                   mismatches,
	output int                   words_due,
	output int                   words_checked
);

	localparam int FRAC = 24;
	localparam longint unsigned ONE_POS  = 64'd1 << FRAC;
	localparam longint unsigned STEP_LO  = ONE_POS >> 3;
	localparam longint unsigned STEP_HI  = ONE_POS << 4;
	localparam longint unsigned RATIO_HI = ONE_POS << 3;
	localparam longint unsigned SEEN_SAT = (64'd1 << 32) - 64'd1;
	localparam longint unsigned EMIT_SAT = (64'd1 << 35) - 64'd1;

	// register copies
	logic        bypass_on;
	logic [28:0] step_reg;
	logic [27:0] ratio_reg;

	// stream state
	logic signed [SAMPLE_W-1:0] prev_sample;
	longint unsigned            phase_pos;
	longint unsigned            seen_count;
	longint unsigned            emitted_count;

	// predicted output words, oldest first
	out_word_t expected_words [$];
	out_word_t want;
	int        fail_tally;
	int        checked_tally;

	task automatic clear_stream();
		prev_sample   = '0;
		phase_pos     = 0;
		seen_count    = 0;
		emitted_count = 0;
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [28:0] value);
		case (cfg_reg_t'(idx))
			REG_BYPASS: bypass_on = value[0];
			REG_STEP:   step_reg  = value;
			REG_RATIO:  ratio_reg = value[27:0];
			default: ;
		endcase
	endtask

	// a + (b - a) * t, rounded to nearest with halves toward +infinity
	function automatic logic signed [SAMPLE_W-1:0] lerp(
		input logic signed [SAMPLE_W-1:0] a,
		input logic signed [SAMPLE_W-1:0] b,
		input longint unsigned            t
	);
		longint diff;
		longint prod;
		diff = longint'(b) - longint'(a);
		prod = diff * longint'(t) + longint'(ONE_POS >> 1);
		return SAMPLE_W'(longint'(a) + (prod >>> FRAC));
	endfunction

	// all output words caused by one input word
	task automatic resample_word(input in_word_t w);
		out_word_t                  batch [MAX_RESULTS];
		logic signed [SAMPLE_W-1:0] cur;
		longint unsigned            step;
		longint unsigned            ratio;
		longint unsigned            limit;
		longint unsigned            remaining;
		longint unsigned            total;
		logic                       first_word;
		int                         n;
		cur = w.sample_value;
		n   = 0;
		if (ratio_reg == '0) begin
			// zero ratio: nothing out, a last word still ends the stream
			if (w.is_last)
				clear_stream();
		end else if (bypass_on) begin
			batch[0] = {cur, 1'b0, w.is_last};
			n = 1;
			if (w.is_last)
				clear_stream();
			else if (seen_count < SEEN_SAT)
				seen_count++;
		end else begin
			// saturate step and ratio into their working ranges
			step = 64'(step_reg);
			if (step < STEP_LO)
				step = STEP_LO;
			if (step > STEP_HI)
				step = STEP_HI;
			ratio = (ratio_reg > RATIO_HI) ? RATIO_HI : longint'(ratio_reg);
			first_word = (seen_count == 0);
			if (first_word)
				prev_sample = cur;
			limit = first_word ? 0 : ONE_POS;
			remaining = MAX_RESULTS;
			if (w.is_last) begin
				total = ((seen_count + 1) * ratio + (ONE_POS >> 1)) >> FRAC;
				remaining = (total > emitted_count) ? total - emitted_count : 0;
			end
			// interpolated outputs up to the current sample
			while (phase_pos <= limit && n < MAX_RESULTS && longint'(n) < remaining) begin
				batch[n] = {lerp(prev_sample, cur, phase_pos), 1'b0, 1'b0};
				n++;
				phase_pos += step;
				if (emitted_count < EMIT_SAT)
					emitted_count++;
			end
			if (w.is_last) begin
				// pad with copies of the last sample up to the rounded total
				while (longint'(n) < remaining && n < MAX_RESULTS) begin
					batch[n] = {cur, 1'b0, 1'b0};
					n++;
				end
				if (n > 0)
					batch[n-1].end_of_stream = 1'b1;
				clear_stream();
			end else begin
				if (!first_word)
					phase_pos = (phase_pos > ONE_POS) ? phase_pos - ONE_POS : 0;
				prev_sample = cur;
				if (seen_count < SEEN_SAT)
					seen_count++;
			end
		end
		if (n > 0)
			batch[n-1].end_of_run = 1'b1;
		for (int k = 0; k < n; k++)
			expected_words = {expected_words, batch[k]};
	endtask

	// follow the channels and compare
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bypass_on     = 1'b0;
			step_reg      = 29'd16777216;
			ratio_reg     = 28'd16777216;
			clear_stream();
			expected_words.delete();
			fail_tally    = 0;
			checked_tally = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				write_register(cfg_index, cfg_data);
			if (in_valid && in_ready)
				resample_word(in_data);
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					$error("output word with none expected: out_value %0d", out_data.out_value);
					fail_tally++;
				end else begin
					want = expected_words.pop_front();
					if (want.out_value !== out_data.out_value) begin
						$error("out_value: expected %0d, got %0d", want.out_value,
							out_data.out_value);
						fail_tally++;
					end
					if (want.end_of_run !== out_data.end_of_run) begin
						$error("end_of_run: expected %0b, got %0b", want.end_of_run,
							out_data.end_of_run);
						fail_tally++;
					end
					if (want.end_of_stream !== out_data.end_of_stream) begin
						$error("end_of_stream: expected %0b, got %0b", want.end_of_stream,
							out_data.end_of_stream);
						fail_tally++;
					end
					checked_tally++;
				end
			end
		end
		mismatches    <= fail_tally;
		words_due     <= expected_words.size();
		words_checked <= checked_tally;
	end

endmodule

FILE: sim/linear_interpolation_resampler_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_interpolation_resampler_test: stimulus and verdict for the resampler
// Walks the block through a series of register settings, sends streams of
// sample words with random gaps on both sides and one long output stall,
// and leaves prediction and comparison to the output checker.
// ----------------------------------------------------------------------------
module linear_interpolation_resampler_test;
	import lir_pkg::*;

	localparam int          HOLD_CYCLES  = 400;
	localparam int          DRAIN_CYCLES = 64;
	localparam int          TOTAL_ITEMS  = 320;
	localparam logic [28:0] ONE_POS      = 29'd1 << 24;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	in_word_t             in_data   = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_word_t            out_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [28:0]          cfg_data  = '0;

	int mismatches;
	int words_due;
	int words_checked;

	// stimulus bookkeeping
	bit steady;
	bit long_hold_pending;
	int words_sent;
	int directed_words;
	int settings_used;

	linear_interpolation_resampler dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	lir_output_checker result_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_data       (in_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_data      (out_data),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mismatches    (mismatches),
		.words_due     (words_due),
		.words_checked (words_checked)
	);

	// clock
	initial begin
		forever #10 clk = ~clk;
	end

	// run limit
	initial begin
		#10_000_000;
		$display("timeout: output words still outstanding");
		$display("linear_interpolation_resampler: mismatch");
		$finish;
	end

	// output side: random stalls, one long hold on request
	initial begin
		int gap;
		@(posedge clk);
		forever begin
			if (long_hold_pending) begin
				long_hold_pending = 1'b0;
				gap = HOLD_CYCLES;
			end else begin
				gap = steady ? 0 : $urandom_range(0, 6);
			end
			if (gap != 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	// offer one input word after a random gap
	task automatic send_word(input logic signed [SAMPLE_W-1:0] value, input logic last);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 6);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid              <= 1'b1;
		in_data.sample_value  <= value;
		in_data.is_last       <= last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		words_sent++;
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [28:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// wait until every predicted word is out and the block has settled
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (words_due != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input logic byp, input logic [28:0] step, input logic [28:0] ratio);
		drain();
		write_reg(REG_BYPASS, {28'd0, byp});
		write_reg(REG_STEP, step);
		write_reg(REG_RATIO, ratio);
		settings_used++;
	endtask

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 7))
			0:       return 24'sh7FFFFF;
			1:       return 24'sh800000;
			2:       return SAMPLE_W'(int'($urandom_range(0, 16)) - 8);
			default: return SAMPLE_W'($urandom());
		endcase
	endfunction

	task automatic send_stream(input int len);
		for (int i = 0; i < len; i++)
			send_word(pick_sample(), i == len - 1);
	endtask

	// stimulus
	initial begin
		int          mode;
		int          streams;
		int          len;
		logic        byp;
		logic [28:0] step;
		logic [28:0] ratio;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unity rate, sample extremes, first word copy
		configure(1'b0, ONE_POS, ONE_POS);
		send_word(24'sh7FFFFF, 1'b0);
		send_word(24'sh800000, 1'b0);
		send_word(24'sh000000, 1'b0);
		send_word(-24'sd1, 1'b1);
		// single-word stream
		send_word(24'sh800000, 1'b1);
		// bypass
		configure(1'b1, ONE_POS, ONE_POS);
		send_word(24'sh7FFFFF, 1'b0);
		send_word(24'sh800000, 1'b1);
		// zero ratio
		configure(1'b0, ONE_POS, 29'd0);
		send_word(24'sd5, 1'b0);
		send_word(-24'sd7, 1'b1);
		// step below range, ratio above eight
		configure(1'b0, 29'd0, 29'h1FFF_FFFF);
		send_word(24'sh800000, 1'b0);
		send_word(24'sh7FFFFF, 1'b0);
		send_word(24'sh000000, 1'b1);
		// step above range with small ratio: total already exceeded
		configure(1'b0, 29'h1FFF_FFFF, ONE_POS >> 4);
		send_word(24'sd100, 1'b0);
		send_word(24'sd200, 1'b0);
		send_word(24'sd300, 1'b1);
		// inconsistent step and ratio: padding cut at the per-word limit
		configure(1'b0, ONE_POS << 4, ONE_POS << 3);
		send_word(24'sd11, 1'b0);
		send_word(-24'sd11, 1'b0);
		send_word(24'sh400000, 1'b1);
		// half positions round toward +infinity
		configure(1'b0, ONE_POS >> 1, ONE_POS << 1);
		send_word(24'sd0, 1'b0);
		send_word(24'sd1, 1'b0);
		send_word(24'sd0, 1'b0);
		send_word(-24'sd1, 1'b1);
		// half total rounds away from zero
		configure(1'b0, ONE_POS << 1, ONE_POS >> 1);
		send_word(24'sd77, 1'b1);
		directed_words = words_sent;

		// random settings and streams
		while (words_sent < TOTAL_ITEMS) begin
			mode = $urandom_range(0, 9);
			byp  = 1'b0;
			if (settings_used == 8) begin
				// first random setting: full upsampling under a long output hold
				step  = ONE_POS >> 3;
				ratio = ONE_POS << 3;
			end else if (mode == 0) begin
				byp   = 1'b1;
				step  = 29'($urandom());
				ratio = 29'($urandom_range(1, 1 << 28));
			end else if (mode == 1) begin
				step  = 29'($urandom());
				ratio = 29'd0;
			end else if (mode == 2) begin
				step  = 29'($urandom());
				ratio = 29'($urandom());
			end else begin
				case ($urandom_range(0, 4))
					0, 1:    step = 29'($urandom_range(ONE_POS >> 3, ONE_POS));
					2, 3:    step = 29'($urandom_range(ONE_POS, ONE_POS << 2));
					default: step = 29'($urandom_range(ONE_POS << 2, ONE_POS << 4));
				endcase
				ratio = 29'(((64'd1 << 48) + step / 2) / step);
			end
			configure(byp, step, ratio);
			steady = (settings_used % 4 == 3);
			if (settings_used == 9)
				long_hold_pending = 1'b1;
			streams = $urandom_range(1, 4);
			for (int s = 0; s < streams; s++) begin
				case ($urandom_range(0, 7))
					0:       len = 1;
					1:       len = $urandom_range(11, 24);
					default: len = $urandom_range(2, 10);
				endcase
				send_stream(len);
			end
		end
		steady = 1'b0;
		drain();

		$display("sent %0d input words (%0d directed) under %0d register settings",
			words_sent, directed_words, settings_used);
		$display("compared %0d output words, %0d field mismatches", words_checked, mismatches);
		if (mismatches == 0)
			$display("linear_interpolation_resampler: match");
		else
			$display("linear_interpolation_resampler: mismatch");
		$finish;
	end

endmodule

FILE: files.f
sv/lir_pkg.sv
sv/lir_front.sv
sv/lir_back.sv
sv/linear_interpolation_resampler.sv
sim/lir_output_checker.sv
sim/linear_interpolation_resampler_test.sv
